// ===== sv/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, codes and helper functions of the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned QuoW        = 33;  // quotient bits below the saturation mark

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_e;

  // one lane of the long division
  typedef struct packed {
    logic            neg;   // sign of the numerator
    logic            big;   // quotient does not fit below 2^33
    logic [63:0]     rem;   // partial remainder, below den unless big is set
    logic [QuoW-1:0] low;   // numerator bits still to shift in
    logic [QuoW-1:0] quo;   // quotient bits so far
  } lane_t;

  typedef struct packed {
    func_e             func;
    logic              ov;
    logic              dz;
    logic [DataW-1:0]  re;
    logic [DataW-1:0]  im;
    logic [63:0]       den;
    lane_t             l_re;
    lane_t             l_im;
  } pipe_t;

  typedef struct packed {
    logic             dz;
    logic             ov;
    logic [DataW-1:0] im;
    logic [DataW-1:0] re;
  } res_t;

  // saturate to 32-bit two's complement; MSB of result is the overflow flag
  function automatic logic [DataW:0] sat66(input logic signed [65:0] v);
    logic [DataW:0] r;
    if (v > 66'sh0_7FFF_FFFF) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -66'sh0_8000_0000) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[DataW-1:0]};
    end
    return r;
  endfunction

  // one restoring division step: bring in one numerator bit
  function automatic lane_t div_step(input lane_t l, input logic [63:0] den);
    lane_t       n;
    logic [64:0] t;
    logic [64:0] diff;
    logic        qb;
    t    = {l.rem, l.low[QuoW-1]};
    diff = t - {1'b0, den};
    qb   = (t >= {1'b0, den});
    n     = l;
    n.rem = qb ? diff[63:0] : t[63:0];
    n.low = {l.low[QuoW-2:0], 1'b0};
    n.quo = {l.quo[QuoW-2:0], qb};
    return n;
  endfunction

  // signed, saturated quotient of a finished lane; MSB is overflow
  function automatic logic [DataW:0] lane_result(input lane_t l);
    logic        [QuoW:0] mag;
    logic signed [65:0]   v;
    mag = l.big ? {1'b1, {QuoW{1'b0}}} : {1'b0, l.quo};
    v   = $signed({{(66-QuoW-1){1'b0}}, mag});
    if (l.neg) begin
      v = -v;
    end
    return sat66(v);
  endfunction

endpackage : cau_pkg

`default_nettype wire

// ===== sv/complex_arith_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arith_unit
// Pipelined complex add / subtract / multiply / divide on signed fixed point.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Signals          Content (lowest bits first)
// s_axis    in   tdata[127:0]     a_re, a_im, b_re, b_im
//                tuser[1:0]       func (0 add, 1 sub, 2 mul, 3 div)
// m_axis    out  tdata[63:0]      res_re, res_im
//                tuser[1:0]       overflow, div_zero
//
// One transfer per cycle in steady state. The path runs through the input
// register, product stage, sum stage, scale/magnitude stage, divide setup,
// 33 long-division steps (one quotient bit each) and the output register.
// Every operation takes the same path, so results leave in input order.
// Reset clears all valid bits; payload registers are not reset.
// A two-entry output buffer (output register plus skid register) parts the
// stream sides; the pipeline freezes only while the skid register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arith_unit #(
  parameter int unsigned FRAC_BITS = cau_pkg::FracBitsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,   // a_re, a_im, b_re, b_im
  input  wire logic [1:0]   s_axis_tuser,   // func
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [63:0]       m_axis_tdata,   // res_re, res_im
  output logic [1:0]        m_axis_tuser    // overflow, div_zero
);
  import cau_pkg::*;

  localparam int unsigned NumW = 64 + FRAC_BITS;  // scaled division numerator
  localparam int unsigned TopW = NumW - QuoW;     // numerator part above the quotient

  // global advance: the whole pipeline moves unless the skid register holds data
  logic en;

  // ---------------- stage 1: input register ----------------
  logic               s1_vld_q;
  func_e              s1_func_q;
  logic signed [31:0] s1_ar_q, s1_ai_q, s1_br_q, s1_bi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_func_q <= func_e'(s_axis_tuser);
      s1_ar_q   <= s_axis_tdata[31:0];
      s1_ai_q   <= s_axis_tdata[63:32];
      s1_br_q   <= s_axis_tdata[95:64];
      s1_bi_q   <= s_axis_tdata[127:96];
    end
  end

  // ---------------- stage 2: products, add/sub result ----------------
  logic               s2_vld_q;
  func_e              s2_func_q;
  logic signed [63:0] s2_rr_q, s2_ii_q, s2_ri_q, s2_ir_q;  // ar*br, ai*bi, ar*bi, ai*br
  logic        [63:0] s2_br2_q, s2_bi2_q;
  logic        [DataW:0] s2_as_re_q, s2_as_im_q;          // {ov, value}

  logic signed [32:0] as_re, as_im;
  always_comb begin
    if (s1_func_q == FUNC_SUB) begin
      as_re = {s1_ar_q[31], s1_ar_q} - {s1_br_q[31], s1_br_q};
      as_im = {s1_ai_q[31], s1_ai_q} - {s1_bi_q[31], s1_bi_q};
    end else begin
      as_re = {s1_ar_q[31], s1_ar_q} + {s1_br_q[31], s1_br_q};
      as_im = {s1_ai_q[31], s1_ai_q} + {s1_bi_q[31], s1_bi_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_func_q  <= s1_func_q;
      s2_rr_q    <= 64'(s1_ar_q * s1_br_q);
      s2_ii_q    <= 64'(s1_ai_q * s1_bi_q);
      s2_ri_q    <= 64'(s1_ar_q * s1_bi_q);
      s2_ir_q    <= 64'(s1_ai_q * s1_br_q);
      s2_br2_q   <= 64'(s1_br_q * s1_br_q);
      s2_bi2_q   <= 64'(s1_bi_q * s1_bi_q);
      s2_as_re_q <= sat66({{33{as_re[32]}}, as_re});
      s2_as_im_q <= sat66({{33{as_im[32]}}, as_im});
    end
  end

  // ---------------- stage 3: exact product sums, |b|^2 ----------------
  logic               s3_vld_q;
  func_e              s3_func_q;
  logic signed [64:0] s3_sre_q, s3_sim_q;
  logic        [63:0] s3_den_q;
  logic        [DataW:0] s3_as_re_q, s3_as_im_q;

  logic signed [64:0] rr_x, ii_x, ri_x, ir_x;
  assign rr_x = {s2_rr_q[63], s2_rr_q};
  assign ii_x = {s2_ii_q[63], s2_ii_q};
  assign ri_x = {s2_ri_q[63], s2_ri_q};
  assign ir_x = {s2_ir_q[63], s2_ir_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_func_q  <= s2_func_q;
      // multiply: a*b ; divide: a*conj(b)
      s3_sre_q   <= (s2_func_q == FUNC_MUL) ? rr_x - ii_x : rr_x + ii_x;
      s3_sim_q   <= (s2_func_q == FUNC_MUL) ? ri_x + ir_x : ir_x - ri_x;
      s3_den_q   <= s2_br2_q + s2_bi2_q;
      s3_as_re_q <= s2_as_re_q;
      s3_as_im_q <= s2_as_im_q;
    end
  end

  // ---------------- stage 4: scale/saturate, divide magnitudes ----------------
  logic             s4_vld_q;
  func_e            s4_func_q;
  logic             s4_ov_q, s4_dz_q;
  logic [DataW-1:0] s4_re_q, s4_im_q;
  logic [63:0]      s4_den_q;
  logic             s4_neg_re_q, s4_neg_im_q;
  logic [63:0]      s4_mag_re_q, s4_mag_im_q;

  logic signed [64:0] sh_re, sh_im, ng_re, ng_im;
  logic        [DataW:0] mul_re, mul_im;
  assign sh_re  = s3_sre_q >>> FRAC_BITS;  // floor toward minus infinity
  assign sh_im  = s3_sim_q >>> FRAC_BITS;
  assign mul_re = sat66({sh_re[64], sh_re});
  assign mul_im = sat66({sh_im[64], sh_im});
  assign ng_re  = -s3_sre_q;
  assign ng_im  = -s3_sim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_func_q   <= s3_func_q;
      s4_den_q    <= s3_den_q;
      s4_dz_q     <= (s3_func_q == FUNC_DIV) && (s3_den_q == 64'd0);
      s4_neg_re_q <= s3_sre_q[64];
      s4_neg_im_q <= s3_sim_q[64];
      s4_mag_re_q <= s3_sre_q[64] ? ng_re[63:0] : s3_sre_q[63:0];
      s4_mag_im_q <= s3_sim_q[64] ? ng_im[63:0] : s3_sim_q[63:0];
      if (s3_func_q == FUNC_MUL) begin
        s4_re_q <= mul_re[DataW-1:0];
        s4_im_q <= mul_im[DataW-1:0];
        s4_ov_q <= mul_re[DataW] | mul_im[DataW];
      end else begin
        s4_re_q <= s3_as_re_q[DataW-1:0];
        s4_im_q <= s3_as_im_q[DataW-1:0];
        s4_ov_q <= s3_as_re_q[DataW] | s3_as_im_q[DataW];
      end
    end
  end

  // ---------------- stage 5: division setup ----------------
  logic            s5_vld_q;
  pipe_t           s5_q;
  logic [NumW-1:0] num_re, num_im;
  logic [TopW-1:0] top_re, top_im;
  pipe_t           s5_d;

  always_comb begin
    num_re = NumW'(s4_mag_re_q) << FRAC_BITS;
    num_im = NumW'(s4_mag_im_q) << FRAC_BITS;
    top_re = num_re[NumW-1:QuoW];
    top_im = num_im[NumW-1:QuoW];
    s5_d.func     = s4_func_q;
    s5_d.ov       = s4_ov_q;
    s5_d.dz       = s4_dz_q;
    s5_d.re       = s4_re_q;
    s5_d.im       = s4_im_q;
    s5_d.den      = s4_den_q;
    // quotient reaches 2^33 exactly when the top part is not below den
    s5_d.l_re.neg = s4_neg_re_q;
    s5_d.l_re.big = 64'(top_re) >= s4_den_q;
    s5_d.l_re.rem = 64'(top_re);
    s5_d.l_re.low = num_re[QuoW-1:0];
    s5_d.l_re.quo = '0;
    s5_d.l_im.neg = s4_neg_im_q;
    s5_d.l_im.big = 64'(top_im) >= s4_den_q;
    s5_d.l_im.rem = 64'(top_im);
    s5_d.l_im.low = num_im[QuoW-1:0];
    s5_d.l_im.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_q <= s5_d;
    end
  end

  // ---------------- division steps: one quotient bit per stage ----------------
  logic  [QuoW-1:0] dv_vld_q;
  pipe_t            dv_q [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_div
    pipe_t src;
    pipe_t nxt;
    logic  src_vld;
    if (k == 0) begin : g_first
      assign src     = s5_q;
      assign src_vld = s5_vld_q;
    end else begin : g_next
      assign src     = dv_q[k-1];
      assign src_vld = dv_vld_q[k-1];
    end

    always_comb begin
      nxt      = src;
      nxt.l_re = div_step(src.l_re, src.den);
      nxt.l_im = div_step(src.l_im, src.den);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else if (en) begin
        dv_vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[k] <= nxt;
      end
    end
  end

  // ---------------- result select ----------------
  pipe_t          last;
  res_t           fin;
  logic [DataW:0] dq_re, dq_im;
  logic           push;

  assign last  = dv_q[QuoW-1];
  assign dq_re = lane_result(last.l_re);
  assign dq_im = lane_result(last.l_im);
  assign push  = en && dv_vld_q[QuoW-1];

  always_comb begin
    fin.dz = 1'b0;
    fin.ov = last.ov;
    fin.re = last.re;
    fin.im = last.im;
    if (last.func == FUNC_DIV) begin
      if (last.dz) begin
        fin.dz = 1'b1;
        fin.ov = 1'b0;
        fin.re = '0;
        fin.im = '0;
      end else begin
        fin.ov = dq_re[DataW] | dq_im[DataW];
        fin.re = dq_re[DataW-1:0];
        fin.im = dq_im[DataW-1:0];
      end
    end
  end

  // ---------------- output register + skid register ----------------
  logic out_vld_q, skid_vld_q;
  res_t out_q, skid_q;

  assign en = !skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q  <= skid_vld_q || push;
      skid_vld_q <= 1'b0;
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || m_axis_tready) begin
      out_q <= skid_vld_q ? skid_q : fin;
    end else if (push) begin
      skid_q <= fin;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.im, out_q.re};
  assign m_axis_tuser  = {out_q.dz, out_q.ov};

  // ---------------- assertions ----------------
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register full while output register empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !m_axis_tready))
    else $error("skid register filled without an output stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.dz) |-> (out_q.re == '0 && out_q.im == '0 && !out_q.ov))
    else $error("zero-divisor result not cleared");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> (!push && !s_axis_tready))
    else $error("pipeline advanced into a full output buffer");

endmodule : complex_arith_unit

`default_nettype wire
